### rtl/rac_pkg.sv
// shared types, widths and codes for the rational accumulator
package rac_pkg;

    // accumulator and operand widths
    localparam int ACC_BITS     = 40;
    localparam int OPERAND_BITS = 8;

    // magnitude width of a non-negative accumulator value
    localparam int VAL_W  = ACC_BITS - 1;
    // width of the shared adder, wide enough for value times operand
    localparam int PROD_W = VAL_W + OPERAND_BITS;
    // step counter covers the multiply and the divide loops
    localparam int CNT_MAX = (OPERAND_BITS > VAL_W) ? OPERAND_BITS : VAL_W;
    localparam int CNT_W   = $clog2(CNT_MAX);

    // operation codes
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // multiply job: accumulator source
    localparam logic [1:0] SRC_W = 2'd0;
    localparam logic [1:0] SRC_N = 2'd1;
    localparam logic [1:0] SRC_D = 2'd2;

    // multiply job: operand source
    localparam logic [1:0] OPD_X = 2'd0;
    localparam logic [1:0] OPD_P = 2'd1;
    localparam logic [1:0] OPD_Q = 2'd2;

    // multiply job: product destination
    localparam logic [2:0] DST_T1 = 3'd0;
    localparam logic [2:0] DST_T2 = 3'd1;
    localparam logic [2:0] DST_N  = 3'd2;
    localparam logic [2:0] DST_D  = 3'd3;
    localparam logic [2:0] DST_W  = 3'd4;

    // final step after the multiply jobs
    localparam logic [1:0] FIN_NONE = 2'd0;
    localparam logic [1:0] FIN_ADD  = 2'd1;
    localparam logic [1:0] FIN_SUB  = 2'd2;
    localparam logic [1:0] FIN_DIV  = 2'd3;

    // input beat
    typedef struct packed {
        logic                    start_req;
        logic [1:0]              op;
        logic                    operand_is_fraction;
        logic [OPERAND_BITS-1:0] operand_whole;
        logic [OPERAND_BITS-1:0] operand_numer;
        logic [OPERAND_BITS-1:0] operand_denom;
    } t_in_item;

    // output beat
    typedef struct packed {
        logic                       acc_is_fraction;
        logic signed [ACC_BITS-1:0] acc_whole;
        logic signed [ACC_BITS-1:0] acc_numer;
        logic [VAL_W-1:0]           acc_denom;
        logic                       negative;
        logic                       overflow;
    } t_out_item;

    // handshake between top level and core
    typedef struct packed {
        logic fire;
        logic ack;
    } t_core_req;

    typedef struct packed {
        logic idle;
        logic done;
    } t_core_stat;

    // shared adder request and result
    typedef struct packed {
        logic              sub;
        logic [PROD_W-1:0] a;
        logic [PROD_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic              carry;
        logic [PROD_W-1:0] sum;
    } t_alu_res;

    // one queued multiply
    typedef struct packed {
        logic [1:0] src;
        logic [1:0] opd;
        logic [2:0] dst;
    } t_job;

    function automatic t_job mk_job(logic [1:0] src, logic [1:0] opd, logic [2:0] dst);
        t_job j;
        j.src = src;
        j.opd = opd;
        j.dst = dst;
        return j;
    endfunction

endpackage

### rtl/rac_alu.sv
// shared add/subtract unit used by the multiply, add and divide steps of the sequencer
module rac_alu (
    input  rac_pkg::t_alu_req i_req,
    output rac_pkg::t_alu_res o_res
);
    import rac_pkg::*;

    logic [PROD_W:0] full;

    // carry-out is the no-borrow flag when subtracting
    assign full = {1'b0, i_req.a}
                + {1'b0, (i_req.sub ? ~i_req.b : i_req.b)}
                + (PROD_W+1)'(i_req.sub);

    assign o_res.carry = full[PROD_W];
    assign o_res.sum   = full[PROD_W-1:0];

endmodule

### rtl/rac_core.sv
// accumulator state and step sequencer around the shared adder
module rac_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rac_pkg::t_core_req i_req,
    input  rac_pkg::t_in_item  i_in,
    output rac_pkg::t_core_stat o_stat,
    output rac_pkg::t_out_item o_acc
);
    import rac_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL    = 3'd1;
    localparam logic [2:0] ST_ADD    = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_COMMIT = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0] r_state, n_state;

    // committed accumulator
    logic                r_kind, n_kind;
    logic [ACC_BITS-1:0] r_whole, n_whole;
    logic [ACC_BITS-1:0] r_numer, n_numer;
    logic [ACC_BITS-1:0] r_denom, n_denom;
    logic                r_neg, n_neg;
    logic                r_ovf, n_ovf;

    // latched operand
    logic [OPERAND_BITS-1:0] r_x, n_x;
    logic [OPERAND_BITS-1:0] r_p, n_p;
    logic [OPERAND_BITS-1:0] r_q, n_q;

    // job queue and plan
    t_job       r_job0, n_job0;
    t_job       r_job1, n_job1;
    t_job       r_job2, n_job2;
    logic [1:0] r_njob, n_njob;
    logic [1:0] r_fin, n_fin;
    logic       r_fin_w, n_fin_w;
    logic       r_ok, n_ok;
    logic       r_neg_w, n_neg_w;

    // working copy of the result
    logic                r_wk_kind, n_wk_kind;
    logic [ACC_BITS-1:0] r_wk_whole, n_wk_whole;
    logic [ACC_BITS-1:0] r_wk_numer, n_wk_numer;
    logic [ACC_BITS-1:0] r_wk_denom, n_wk_denom;
    logic [VAL_W-1:0]    r_t1, n_t1;
    logic [VAL_W-1:0]    r_t2, n_t2;

    // iteration registers
    logic [PROD_W-1:0]       r_prod, n_prod;
    logic [OPERAND_BITS-1:0] r_mpl, n_mpl;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic [VAL_W-1:0]        r_quot, n_quot;
    logic [OPERAND_BITS-1:0] r_rem, n_rem;

    t_alu_req            alu_req;
    t_alu_res            alu_res;
    logic [VAL_W-1:0]    prod_lo;
    logic [ACC_BITS-1:0] add_res;
    logic                qbit;
    logic [1:0]          sel;

    rac_alu u_alu (
        .i_req (alu_req),
        .o_res (alu_res)
    );

    function automatic logic [OPERAND_BITS-1:0] opd_pick(
        logic [1:0] opd, logic [OPERAND_BITS-1:0] x,
        logic [OPERAND_BITS-1:0] p, logic [OPERAND_BITS-1:0] q);
        logic [OPERAND_BITS-1:0] v;
        case (opd)
            OPD_X:   v = x;
            OPD_P:   v = p;
            OPD_Q:   v = q;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [VAL_W-1:0] src_pick(
        logic [1:0] src, logic [ACC_BITS-1:0] w,
        logic [ACC_BITS-1:0] n, logic [ACC_BITS-1:0] d);
        logic [VAL_W-1:0] v;
        case (src)
            SRC_W:   v = w[VAL_W-1:0];
            SRC_N:   v = n[VAL_W-1:0];
            SRC_D:   v = d[VAL_W-1:0];
            default: v = '0;
        endcase
        return v;
    endfunction

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        n_whole    = r_whole;
        n_numer    = r_numer;
        n_denom    = r_denom;
        n_neg      = r_neg;
        n_ovf      = r_ovf;
        n_x        = r_x;
        n_p        = r_p;
        n_q        = r_q;
        n_job0     = r_job0;
        n_job1     = r_job1;
        n_job2     = r_job2;
        n_njob     = r_njob;
        n_fin      = r_fin;
        n_fin_w    = r_fin_w;
        n_ok       = r_ok;
        n_neg_w    = r_neg_w;
        n_wk_kind  = r_wk_kind;
        n_wk_whole = r_wk_whole;
        n_wk_numer = r_wk_numer;
        n_wk_denom = r_wk_denom;
        n_t1       = r_t1;
        n_t2       = r_t2;
        n_prod     = r_prod;
        n_mpl      = r_mpl;
        n_cnt      = r_cnt;
        n_quot     = r_quot;
        n_rem      = r_rem;
        alu_req    = '0;
        prod_lo    = alu_res.sum[VAL_W-1:0];
        add_res    = alu_res.sum[ACC_BITS-1:0];
        qbit       = alu_res.carry;
        sel        = {r_kind, i_in.operand_is_fraction};

        case (r_state)
            ST_IDLE: begin
                if (i_req.fire) begin
                    n_x = i_in.operand_whole;
                    n_p = i_in.operand_numer;
                    n_q = i_in.operand_denom;
                    if (i_in.start_req) begin
                        // load operand as the new accumulator
                        n_kind  = i_in.operand_is_fraction;
                        n_whole = i_in.operand_is_fraction ? '0
                                                           : ACC_BITS'(i_in.operand_whole);
                        n_numer = i_in.operand_is_fraction ? ACC_BITS'(i_in.operand_numer)
                                                           : ACC_BITS'(1);
                        n_denom = i_in.operand_is_fraction ? ACC_BITS'(i_in.operand_denom)
                                                           : ACC_BITS'(1);
                        n_neg   = 1'b0;
                        n_ovf   = 1'b0;
                        n_state = ST_DONE;
                    end else if (r_neg || r_ovf) begin
                        n_state = ST_DONE;
                    end else begin
                        // plan the multiply jobs and the final step
                        n_njob     = 2'd0;
                        n_fin      = FIN_NONE;
                        n_fin_w    = 1'b0;
                        n_ok       = 1'b1;
                        n_neg_w    = 1'b0;
                        n_wk_kind  = r_kind;
                        n_wk_whole = r_whole;
                        n_wk_numer = r_numer;
                        n_wk_denom = r_denom;
                        n_t1       = '0;
                        n_t2       = '0;
                        case (i_in.op)
                            OP_ADD, OP_SUB: begin
                                n_fin = (i_in.op == OP_ADD) ? FIN_ADD : FIN_SUB;
                                case (sel)
                                    2'b00: begin
                                        n_t1    = r_whole[VAL_W-1:0];
                                        n_t2    = VAL_W'(i_in.operand_whole);
                                        n_fin_w = 1'b1;
                                    end
                                    2'b11: begin
                                        if (r_denom == ACC_BITS'(i_in.operand_denom)) begin
                                            n_t1 = r_numer[VAL_W-1:0];
                                            n_t2 = VAL_W'(i_in.operand_numer);
                                        end else begin
                                            n_job0 = mk_job(SRC_N, OPD_Q, DST_T1);
                                            n_job1 = mk_job(SRC_D, OPD_P, DST_T2);
                                            n_job2 = mk_job(SRC_D, OPD_Q, DST_D);
                                            n_njob = 2'd3;
                                        end
                                    end
                                    2'b01: begin
                                        n_job0     = mk_job(SRC_W, OPD_Q, DST_T1);
                                        n_njob     = 2'd1;
                                        n_t2       = VAL_W'(i_in.operand_numer);
                                        n_wk_kind  = 1'b1;
                                        n_wk_whole = '0;
                                        n_wk_denom = ACC_BITS'(i_in.operand_denom);
                                    end
                                    default: begin
                                        n_t1   = r_numer[VAL_W-1:0];
                                        n_job0 = mk_job(SRC_D, OPD_X, DST_T2);
                                        n_njob = 2'd1;
                                    end
                                endcase
                            end
                            OP_MUL: begin
                                case (sel)
                                    2'b00: begin
                                        n_job0 = mk_job(SRC_W, OPD_X, DST_W);
                                        n_njob = 2'd1;
                                    end
                                    2'b11: begin
                                        n_job0 = mk_job(SRC_D, OPD_Q, DST_D);
                                        n_job1 = mk_job(SRC_N, OPD_P, DST_N);
                                        n_njob = 2'd2;
                                    end
                                    2'b01: begin
                                        n_job0     = mk_job(SRC_W, OPD_P, DST_N);
                                        n_njob     = 2'd1;
                                        n_wk_kind  = 1'b1;
                                        n_wk_whole = '0;
                                        n_wk_denom = ACC_BITS'(i_in.operand_denom);
                                    end
                                    default: begin
                                        n_job0 = mk_job(SRC_N, OPD_X, DST_N);
                                        n_njob = 2'd1;
                                    end
                                endcase
                            end
                            default: begin
                                case (sel)
                                    2'b00: begin
                                        if (i_in.operand_whole == '0) n_ok = 1'b0;
                                        else                          n_fin = FIN_DIV;
                                    end
                                    2'b11: begin
                                        if (i_in.operand_numer == '0) begin
                                            n_ok = 1'b0;
                                        end else begin
                                            n_job0 = mk_job(SRC_D, OPD_P, DST_D);
                                            n_job1 = mk_job(SRC_N, OPD_Q, DST_N);
                                            n_njob = 2'd2;
                                        end
                                    end
                                    2'b01: begin
                                        if (i_in.operand_numer == '0) begin
                                            n_ok = 1'b0;
                                        end else begin
                                            n_job0     = mk_job(SRC_W, OPD_Q, DST_N);
                                            n_njob     = 2'd1;
                                            n_wk_kind  = 1'b1;
                                            n_wk_whole = '0;
                                            n_wk_denom = ACC_BITS'(i_in.operand_numer);
                                        end
                                    end
                                    default: begin
                                        if (i_in.operand_whole == '0) begin
                                            n_ok = 1'b0;
                                        end else begin
                                            n_job0 = mk_job(SRC_D, OPD_X, DST_D);
                                            n_njob = 2'd1;
                                        end
                                    end
                                endcase
                            end
                        endcase

                        // pick the first step
                        if (n_njob != 2'd0) begin
                            n_mpl   = opd_pick(n_job0.opd, i_in.operand_whole,
                                               i_in.operand_numer, i_in.operand_denom);
                            n_cnt   = CNT_W'(OPERAND_BITS-1);
                            n_state = ST_MUL;
                        end else if (n_fin == FIN_ADD || n_fin == FIN_SUB) begin
                            n_state = ST_ADD;
                        end else if (n_fin == FIN_DIV) begin
                            n_quot  = r_whole[VAL_W-1:0];
                            n_rem   = '0;
                            n_cnt   = CNT_W'(VAL_W-1);
                            n_state = ST_DIV;
                        end else begin
                            n_state = ST_COMMIT;
                        end
                    end
                end
            end

            // shift-add multiply, operand msb first
            ST_MUL: begin
                alu_req.sub = 1'b0;
                alu_req.a   = (r_cnt == CNT_W'(OPERAND_BITS-1)) ? '0
                                                                : {r_prod[PROD_W-2:0], 1'b0};
                alu_req.b   = r_mpl[OPERAND_BITS-1]
                            ? PROD_W'(src_pick(r_job0.src, r_whole, r_numer, r_denom))
                            : '0;
                n_prod = alu_res.sum;
                n_mpl  = {r_mpl[OPERAND_BITS-2:0], 1'b0};
                n_cnt  = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    if (alu_res.sum[PROD_W-1:VAL_W] != '0) n_ok = 1'b0;
                    case (r_job0.dst)
                        DST_T1:  n_t1       = prod_lo;
                        DST_T2:  n_t2       = prod_lo;
                        DST_N:   n_wk_numer = {1'b0, prod_lo};
                        DST_D:   n_wk_denom = {1'b0, prod_lo};
                        DST_W:   n_wk_whole = {1'b0, prod_lo};
                        default: ;
                    endcase
                    if (r_njob > 2'd1) begin
                        n_job0 = r_job1;
                        n_job1 = r_job2;
                        n_njob = r_njob - 2'd1;
                        n_mpl  = opd_pick(r_job1.opd, r_x, r_p, r_q);
                        n_cnt  = CNT_W'(OPERAND_BITS-1);
                    end else begin
                        n_njob  = 2'd0;
                        n_state = (r_fin == FIN_ADD || r_fin == FIN_SUB) ? ST_ADD : ST_COMMIT;
                    end
                end
            end

            // final sum or difference of the two terms
            ST_ADD: begin
                alu_req.sub = (r_fin == FIN_SUB);
                alu_req.a   = PROD_W'(r_t1);
                alu_req.b   = PROD_W'(r_t2);
                if (r_fin == FIN_SUB)          n_neg_w = !alu_res.carry;
                else if (alu_res.sum[VAL_W])   n_ok    = 1'b0;
                if (r_fin_w) n_wk_whole = add_res;
                else         n_wk_numer = add_res;
                n_state = ST_COMMIT;
            end

            // restoring division, one quotient bit per step
            ST_DIV: begin
                alu_req.sub = 1'b1;
                alu_req.a   = PROD_W'({r_rem, r_quot[VAL_W-1]});
                alu_req.b   = PROD_W'(r_x);
                n_rem  = qbit ? alu_res.sum[OPERAND_BITS-1:0]
                              : {r_rem[OPERAND_BITS-2:0], r_quot[VAL_W-1]};
                n_quot = {r_quot[VAL_W-2:0], qbit};
                n_cnt  = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    if (n_rem == '0) begin
                        n_wk_whole = {1'b0, n_quot};
                    end else begin
                        n_wk_kind  = 1'b1;
                        n_wk_numer = r_whole;
                        n_wk_denom = ACC_BITS'(r_x);
                        n_wk_whole = '0;
                    end
                    n_state = ST_COMMIT;
                end
            end

            // write back or flag overflow
            ST_COMMIT: begin
                if (r_ok) begin
                    n_kind  = r_wk_kind;
                    n_whole = r_wk_whole;
                    n_numer = r_wk_numer;
                    n_denom = r_wk_denom;
                    if (r_neg_w) n_neg = 1'b1;
                end else begin
                    n_ovf = 1'b1;
                end
                n_state = ST_DONE;
            end

            ST_DONE: begin
                if (i_req.ack) n_state = ST_IDLE;
            end

            default: n_state = ST_IDLE;
        endcase
    end

    // control and accumulator registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_kind  <= 1'b0;
            r_whole <= '0;
            r_numer <= ACC_BITS'(1);
            r_denom <= ACC_BITS'(1);
            r_neg   <= 1'b0;
            r_ovf   <= 1'b0;
            r_njob  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
            r_whole <= n_whole;
            r_numer <= n_numer;
            r_denom <= n_denom;
            r_neg   <= n_neg;
            r_ovf   <= n_ovf;
            r_njob  <= n_njob;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_p        <= n_p;
        r_q        <= n_q;
        r_job0     <= n_job0;
        r_job1     <= n_job1;
        r_job2     <= n_job2;
        r_fin      <= n_fin;
        r_fin_w    <= n_fin_w;
        r_ok       <= n_ok;
        r_neg_w    <= n_neg_w;
        r_wk_kind  <= n_wk_kind;
        r_wk_whole <= n_wk_whole;
        r_wk_numer <= n_wk_numer;
        r_wk_denom <= n_wk_denom;
        r_t1       <= n_t1;
        r_t2       <= n_t2;
        r_prod     <= n_prod;
        r_mpl      <= n_mpl;
        r_cnt      <= n_cnt;
        r_quot     <= n_quot;
        r_rem      <= n_rem;
    end

    // status and accumulator view
    assign o_stat.idle = (r_state == ST_IDLE);
    assign o_stat.done = (r_state == ST_DONE);

    assign o_acc.acc_is_fraction = r_kind;
    assign o_acc.acc_whole       = r_whole;
    assign o_acc.acc_numer       = r_numer;
    assign o_acc.acc_denom       = r_denom[VAL_W-1:0];
    assign o_acc.negative        = r_neg;
    assign o_acc.overflow        = r_ovf;

endmodule

### rtl/rational_accumulator_alu_unit.sv
// Rational accumulator: input handshake, core sequencer and output register.
// Path from input beat to output register: a start or a frozen beat goes straight to done;
// other beats run up to three multiplies (OPERAND_BITS steps each), an add/subtract if needed,
// or natural by natural division (ACC_BITS-1 restoring steps), then commit, all on one adder.
// A new input beat is taken once the previous one has moved to the output register.
// Synchronous active-low reset: accumulator is natural 0 (numer 1, denom 1), flags clear.
module rational_accumulator_alu_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  rac_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output rac_pkg::t_out_item o_out_data
);
    import rac_pkg::*;

    t_core_req  core_req;
    t_core_stat core_stat;
    t_out_item  core_acc;
    logic       take;
    logic       r_out_valid;
    t_out_item  r_out_data;

    rac_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (core_req),
        .i_in    (i_in_data),
        .o_stat  (core_stat),
        .o_acc   (core_acc)
    );

    // input beat taken only while the core is idle
    assign o_in_stall    = !core_stat.idle;
    assign core_req.fire = i_in_valid && core_stat.idle;

    // move a finished result into the output register when it is free
    assign take         = core_stat.done && (!r_out_valid || !i_out_stall);
    assign core_req.ack = take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) r_out_data <= core_acc;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

### rtl/rac_checker.sv
// port-level checks for the rational accumulator, bound to the top level
module rac_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input rac_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input rac_pkg::t_out_item o_out_data
);
    import rac_pkg::*;

    // block is busy right after it takes a beat
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while previous beat still in work");

    // a stalled output beat stays and holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled output beat changed");

    // a natural accumulator always shows numer 1 and denom 1
    a_natural_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.acc_is_fraction) |->
        (o_out_data.acc_numer == ACC_BITS'(1) && o_out_data.acc_denom == VAL_W'(1)))
        else $error("natural result with fraction fields set");

    // a fraction accumulator always shows whole 0
    a_fraction_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.acc_is_fraction) |-> (o_out_data.acc_whole == '0))
        else $error("fraction result with nonzero whole part");

endmodule

bind rational_accumulator_alu_unit rac_checker u_rac_checker (.*);

### test/rational_accumulator_alu_unit_tb.sv
// self-checking testbench for the rational accumulator unit
module rational_accumulator_alu_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rac_pkg::*;

    // largest non-negative accumulator value
    localparam logic [63:0] ACC_LIMIT = (64'd1 << (ACC_BITS - 1)) - 64'd1;

    // accumulator kind paired with operand kind
    localparam logic [1:0] KIND_NN = 2'd0;
    localparam logic [1:0] KIND_NF = 2'd1;
    localparam logic [1:0] KIND_FN = 2'd2;
    localparam logic [1:0] KIND_FF = 2'd3;

    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int PHASE_ITEMS    = 330;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    // predicted accumulator state
    logic        acc_kind = 1'b0;
    logic [63:0] acc_w = 64'd0;
    logic [63:0] acc_n = 64'd1;
    logic [63:0] acc_d = 64'd1;
    logic        flag_neg = 1'b0;
    logic        flag_ovf = 1'b0;

    t_in_item  beat_q[$];
    t_out_item expected_acc_q[$];

    bit in_fire = 1'b0;
    bit out_fire = 1'b0;
    int err_cnt = 0;
    int quiet_cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit pressure_req = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;

    rational_accumulator_alu_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    // 100 MHz clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // product within the accumulator range
    function automatic bit mul_fits(input logic [63:0] a, input logic [63:0] b,
                                    output logic [63:0] r);
        r = a * b;
        if (a == 64'd0) return 1'b1;
        return b <= ACC_LIMIT / a;
    endfunction

    // apply one beat to the predicted accumulator, return the expected output
    function automatic t_out_item accumulate(input t_in_item b);
        logic [63:0] x, p, q, w, n, d, t1, t2, res;
        logic        k, ok, neg;
        logic [1:0]  kinds;
        t_out_item   r;
        x = 64'(b.operand_whole);
        p = 64'(b.operand_numer);
        q = 64'(b.operand_denom);
        if (b.start_req) begin
            acc_kind = b.operand_is_fraction;
            acc_w    = b.operand_is_fraction ? 64'd0 : x;
            acc_n    = b.operand_is_fraction ? p : 64'd1;
            acc_d    = b.operand_is_fraction ? q : 64'd1;
            flag_neg = 1'b0;
            flag_ovf = 1'b0;
        end else if (!flag_neg && !flag_ovf) begin
            k = acc_kind;
            w = acc_w;
            n = acc_n;
            d = acc_d;
            t1 = 64'd0;
            t2 = 64'd0;
            res = 64'd0;
            ok = 1'b1;
            neg = 1'b0;
            kinds = {acc_kind, b.operand_is_fraction};
            case (b.op)
                OP_ADD, OP_SUB: begin
                    // bring both sides to a common form first
                    case (kinds)
                        KIND_NN: begin
                            t1 = w;
                            t2 = x;
                        end
                        KIND_FF: begin
                            if (d == q) begin
                                t1 = n;
                                t2 = p;
                            end else begin
                                ok = mul_fits(n, q, t1);
                                if (ok) ok = mul_fits(p, d, t2);
                                if (ok) ok = mul_fits(d, q, d);
                            end
                        end
                        KIND_NF: begin
                            ok = mul_fits(w, q, t1);
                            t2 = p;
                            k = 1'b1;
                            w = 64'd0;
                            d = q;
                        end
                        default: begin
                            t1 = n;
                            ok = mul_fits(x, d, t2);
                        end
                    endcase
                    if (ok) begin
                        if (b.op == OP_ADD) begin
                            res = t1 + t2;
                            ok = res <= ACC_LIMIT;
                        end else begin
                            res = t1 - t2;
                            neg = t1 < t2;
                        end
                        if (kinds == KIND_NN) w = res;
                        else n = res;
                    end
                end
                OP_MUL: begin
                    case (kinds)
                        KIND_NN: ok = mul_fits(w, x, w);
                        KIND_FF: begin
                            ok = mul_fits(d, q, d);
                            if (ok) ok = mul_fits(n, p, n);
                        end
                        KIND_NF: begin
                            ok = mul_fits(w, p, n);
                            d = q;
                            w = 64'd0;
                            k = 1'b1;
                        end
                        default: ok = mul_fits(x, n, n);
                    endcase
                end
                default: begin
                    // divide, a zero divisor counts as overflow
                    case (kinds)
                        KIND_NN: begin
                            if (x == 64'd0) begin
                                ok = 1'b0;
                            end else if (w % x == 64'd0) begin
                                w = w / x;
                            end else begin
                                k = 1'b1;
                                n = w;
                                d = x;
                                w = 64'd0;
                            end
                        end
                        KIND_FF: begin
                            ok = p != 64'd0;
                            if (ok) ok = mul_fits(d, p, d);
                            if (ok) ok = mul_fits(n, q, n);
                        end
                        KIND_NF: begin
                            ok = p != 64'd0;
                            if (ok) ok = mul_fits(w, q, n);
                            d = p;
                            w = 64'd0;
                            k = 1'b1;
                        end
                        default: begin
                            ok = x != 64'd0;
                            if (ok) ok = mul_fits(x, d, d);
                        end
                    endcase
                end
            endcase
            // commit, or freeze on overflow
            if (!ok) begin
                flag_ovf = 1'b1;
            end else begin
                acc_kind = k;
                acc_w = w;
                acc_n = n;
                acc_d = d;
                if (neg) flag_neg = 1'b1;
            end
        end
        r.acc_is_fraction = acc_kind;
        r.acc_whole       = acc_w[ACC_BITS-1:0];
        r.acc_numer       = acc_n[ACC_BITS-1:0];
        r.acc_denom       = acc_d[VAL_W-1:0];
        r.negative        = flag_neg;
        r.overflow        = flag_ovf;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            err_cnt++;
        end
    endtask

    task automatic push_beat(input bit start, input logic [1:0] op, input bit frac,
                             input int x, input int p, input int q);
        t_in_item b;
        b.start_req           = start;
        b.op                  = op;
        b.operand_is_fraction = frac;
        b.operand_whole       = x[OPERAND_BITS-1:0];
        b.operand_numer       = p[OPERAND_BITS-1:0];
        b.operand_denom       = q[OPERAND_BITS-1:0];
        beat_q.push_back(b);
    endtask

    // random operand, mostly small and well formed
    function automatic t_in_item rand_beat(input bit start);
        t_in_item b;
        int       sel, den;
        b = t_in_item'($urandom);
        b.start_req = start;
        sel = $urandom_range(0, 99);
        if (sel < 35) b.op = OP_ADD;
        else if (sel < 50) b.op = OP_SUB;
        else if (sel < 75) b.op = OP_MUL;
        else b.op = OP_DIV;
        if ($urandom_range(0, 1) == 0) b.operand_whole = OPERAND_BITS'($urandom_range(0, 15));
        den = ($urandom_range(0, 1) == 0) ? $urandom_range(2, 9) : $urandom_range(2, 255);
        if ($urandom_range(0, 19) != 0) begin
            b.operand_denom = den[OPERAND_BITS-1:0];
            b.operand_numer = OPERAND_BITS'($urandom_range(1, den - 1));
        end
        return b;
    endfunction

    // start followed by a short run of operations, with some noise
    task automatic push_sequences(input int count);
        int pushed;
        int ops;
        pushed = 0;
        while (pushed < count) begin
            if ($urandom_range(0, 9) == 0) begin
                beat_q.push_back(t_in_item'($urandom));
                pushed++;
            end else begin
                beat_q.push_back(rand_beat(1'b1));
                ops = $urandom_range(1, 8);
                pushed += ops + 1;
                repeat (ops) beat_q.push_back(rand_beat(1'b0));
            end
        end
    endtask

    task automatic wait_drained();
        while (beat_q.size() != 0 || i_in_valid || expected_acc_q.size() != 0)
            @(posedge i_clk);
    endtask

    // input driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_fire)) begin
            if (beat_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_in_data  <= beat_q.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output stall, with one long hold to back the block up
    always @(negedge i_clk) begin
        if (pressure_req && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // monitor: predict on accepted input beats, check accepted output beats
    always @(posedge i_clk) begin
        in_fire  = i_rst_n && i_in_valid && !o_in_stall;
        out_fire = i_rst_n && o_out_valid && !i_out_stall;
        if (in_fire) expected_acc_q.push_back(accumulate(i_in_data));
        if (out_fire) begin
            if (expected_acc_q.size() == 0) begin
                $error("output beat with no expected result pending");
                err_cnt++;
            end else begin
                t_out_item want;
                want = expected_acc_q.pop_front();
                check_field("acc_is_fraction", 64'(want.acc_is_fraction),
                            64'(o_out_data.acc_is_fraction));
                check_field("acc_whole", 64'(want.acc_whole), 64'(o_out_data.acc_whole));
                check_field("acc_numer", 64'(want.acc_numer), 64'(o_out_data.acc_numer));
                check_field("acc_denom", 64'(want.acc_denom), 64'(o_out_data.acc_denom));
                check_field("negative", 64'(want.negative), 64'(o_out_data.negative));
                check_field("overflow", 64'(want.overflow), 64'(o_out_data.overflow));
            end
        end
        // watchdog on handshake progress
        if (in_fire || out_fire || !i_rst_n) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // stimulus phases
    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // operations on the reset accumulator, then natural zero divisor
        push_beat(1'b0, OP_ADD, 1'b0, 7, 0, 0);
        push_beat(1'b0, OP_DIV, 1'b0, 0, 0, 0);
        push_beat(1'b0, OP_MUL, 1'b0, 3, 0, 0);
        // natural chain ending in an inexact divide
        push_beat(1'b1, OP_DIV, 1'b0, 255, 0, 0);
        push_beat(1'b0, OP_ADD, 1'b0, 255, 0, 0);
        push_beat(1'b0, OP_SUB, 1'b0, 10, 0, 0);
        push_beat(1'b0, OP_MUL, 1'b0, 2, 0, 0);
        push_beat(1'b0, OP_DIV, 1'b0, 3, 0, 0);
        // fraction accumulator against both operand kinds
        push_beat(1'b0, OP_ADD, 1'b1, 0, 1, 3);
        push_beat(1'b0, OP_ADD, 1'b1, 0, 1, 7);
        push_beat(1'b0, OP_SUB, 1'b0, 1, 0, 0);
        push_beat(1'b0, OP_ADD, 1'b0, 2, 0, 0);
        push_beat(1'b0, OP_MUL, 1'b0, 5, 0, 0);
        push_beat(1'b0, OP_MUL, 1'b1, 0, 254, 255);
        push_beat(1'b0, OP_DIV, 1'b1, 0, 3, 4);
        push_beat(1'b0, OP_DIV, 1'b0, 6, 0, 0);
        push_beat(1'b0, OP_DIV, 1'b1, 0, 0, 5);
        // negative result freezes the accumulator
        push_beat(1'b1, OP_ADD, 1'b1, 0, 254, 255);
        push_beat(1'b0, OP_SUB, 1'b1, 0, 255, 255);
        push_beat(1'b0, OP_ADD, 1'b0, 1, 0, 0);
        // zero numerator and denominator taken as given
        push_beat(1'b1, OP_SUB, 1'b0, 0, 0, 0);
        push_beat(1'b0, OP_ADD, 1'b1, 0, 0, 0);
        // natural accumulator with fraction operands, exact natural divide
        push_beat(1'b1, OP_MUL, 1'b0, 9, 0, 0);
        push_beat(1'b0, OP_DIV, 1'b1, 0, 2, 3);
        push_beat(1'b1, OP_ADD, 1'b0, 12, 0, 0);
        push_beat(1'b0, OP_DIV, 1'b0, 4, 0, 0);
        push_beat(1'b1, OP_ADD, 1'b0, 5, 0, 0);
        push_beat(1'b0, OP_MUL, 1'b1, 0, 3, 7);
        push_beat(1'b0, OP_SUB, 1'b1, 0, 6, 1);
        // growth past the accumulator range
        push_beat(1'b1, OP_ADD, 1'b0, 255, 0, 0);
        repeat (4) push_beat(1'b0, OP_MUL, 1'b0, 255, 0, 0);
        wait_drained();

        // no idling, long output hold at the start
        pressure_req = 1'b1;
        push_sequences(PHASE_ITEMS);
        wait_drained();

        send_idle_pct = 67;
        push_sequences(PHASE_ITEMS);
        wait_drained();

        send_idle_pct = 0;
        recv_stall_pct = 67;
        push_sequences(PHASE_ITEMS);
        wait_drained();

        send_idle_pct = 22;
        recv_stall_pct = 22;
        push_sequences(PHASE_ITEMS);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_acc_q.size() != 0) begin
            $error("%0d expected results never arrived", expected_acc_q.size());
            err_cnt++;
        end
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### rational_accumulator_alu_unit.f
rtl/rac_pkg.sv
rtl/rac_alu.sv
rtl/rac_core.sv
rtl/rational_accumulator_alu_unit.sv
rtl/rac_checker.sv
test/rational_accumulator_alu_unit_tb.sv
